[src/ftfi_pkg.sv]
// ----------------------------------------------------------------------------
// ftfi_pkg
// Shared types and constants for the floppy track format image generator.
// ----------------------------------------------------------------------------
package ftfi_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HD_CAPABLE = 3'd5;

  // request opcodes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  // status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  // track geometry
  localparam int SECTOR_BYTES = 512;
  localparam int DISK_RECORD  = SECTOR_BYTES + 102;
  localparam int REGION_W     = 14;
  localparam int GAP_W        = 18;

  localparam logic [REGION_W-1:0] LEAD_IN_DD = 14'd60;
  localparam logic [REGION_W-1:0] LEAD_IN_HD = 14'd120;
  localparam logic [REGION_W-1:0] LEN_GAP2  = 14'd12;
  localparam logic [REGION_W-1:0] LEN_ID    = 14'd9;
  localparam logic [REGION_W-1:0] LEN_GAP3  = 14'd34;
  localparam logic [REGION_W-1:0] LEN_DHEAD = 14'd4;
  localparam logic [REGION_W-1:0] LEN_DATA  = REGION_W'(SECTOR_BYTES);
  localparam logic [REGION_W-1:0] LEN_TAIL  = 14'd41;

  // track size less leader
  localparam logic signed [GAP_W-1:0] GAP_BASE_DD = GAP_W'(6250 - 60);
  localparam logic signed [GAP_W-1:0] GAP_BASE_HD = GAP_W'(12500 - 120);
  localparam logic signed [GAP_W-1:0] GAP_RECORD  = GAP_W'(DISK_RECORD);

  // positions inside regions
  localparam logic [REGION_W-1:0] ID_MARK_IDX   = 14'd3;
  localparam logic [REGION_W-1:0] ID_TRACK_IDX  = 14'd4;
  localparam logic [REGION_W-1:0] ID_SIDE_IDX   = 14'd5;
  localparam logic [REGION_W-1:0] ID_SECTOR_IDX = 14'd6;
  localparam logic [REGION_W-1:0] ID_SIZE_IDX   = 14'd7;
  localparam logic [REGION_W-1:0] SYNC_COUNT    = 14'd3;
  localparam logic [REGION_W-1:0] GAP3_4E_COUNT = 14'd22;

  // track bytes
  localparam logic [7:0] B_GAP   = 8'h4E;
  localparam logic [7:0] B_ZERO  = 8'h00;
  localparam logic [7:0] B_SYNC  = 8'hF5;
  localparam logic [7:0] B_IDAM  = 8'hFE;
  localparam logic [7:0] B_DAM   = 8'hFB;
  localparam logic [7:0] B_CRC   = 8'hF7;
  localparam logic [7:0] B_SIZE  = 8'h02;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LEADER = 4'd1,
    PH_GAP2   = 4'd2,
    PH_ID     = 4'd3,
    PH_GAP3   = 4'd4,
    PH_DHEAD  = 4'd5,
    PH_DATA   = 4'd6,
    PH_TAIL   = 4'd7,
    PH_GAP5   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MOD,
    SEQ_GAP,
    SEQ_SEEK,
    SEQ_OUT
  } seq_state_t;

endpackage

[src/ftfi_req_if.sv]
// ----------------------------------------------------------------------------
// ftfi_req_if
// Request channel: opcode and skew sector number.
// ----------------------------------------------------------------------------
interface ftfi_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] skew_sector;

  modport source (output valid, output opcode, output skew_sector, input ready);
  modport sink   (input valid, input opcode, input skew_sector, output ready);
endinterface

[src/ftfi_rsp_if.sv]
// ----------------------------------------------------------------------------
// ftfi_rsp_if
// Result channel: status, track byte and end-of-image flag.
// ----------------------------------------------------------------------------
interface ftfi_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output status, output data_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input status, input data_byte, input last_byte,
                  output ready);
endinterface

[src/floppy_track_format_image.sv]
// ----------------------------------------------------------------------------
// floppy_track_format_image
// Builds the raw write-track image of one floppy track, one byte per request.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   opcode, skew_sector
//  rsp      out  valid/ready   status, data_byte, last_byte
//  cfg      in   cfg_we        cfg_index, cfg_data
//
//  One request at a time: req.ready is high only when no result is pending.
//  Emit: the request is accepted, then the result sits in the output register;
//  the sector byte of an ID field adds a slot search outside skew mode.
//  Begin: remainder steps (not in skew mode), then the final gap is worked
//  out, all on the one shared subtractor.
//  Reset is synchronous; a stalled rsp holds the block until taken.
//
module floppy_track_format_image #(
  parameter int MAX_SECTORS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ftfi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ftfi_pkg::CFG_DATA_W-1:0]  cfg_data,
  ftfi_req_if.sink                         req,
  ftfi_rsp_if.source                       rsp
);
  import ftfi_pkg::*;

  localparam int MASK_IDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

  // configuration registers
  logic [4:0]         cfg_spt;
  logic [7:0]         cfg_track;
  logic               cfg_side;
  logic signed [7:0]  cfg_ilv;
  logic [15:0]        cfg_fill;
  logic               cfg_hd;

  // sequencer and track state
  seq_state_t               seq, seq_next;
  phase_t                   phase, phase_next;
  logic [REGION_W-1:0]      region_count, region_count_next;
  logic [4:0]               record_index, record_index_next;
  logic [5:0]               sector_offset, sector_offset_next;
  logic [MAX_SECTORS-1:0]   used_mask, used_mask_next;
  logic [4:0]               eff_ilv, eff_ilv_next;
  logic                     track_is_hd, track_is_hd_next;
  logic [4:0]               latched_spt, latched_spt_next;
  logic [REGION_W-1:0]      gap5_len, gap5_len_next;
  logic [4:0]               rem, rem_next;
  logic [4:0]               step_cnt, step_cnt_next;
  logic signed [GAP_W-1:0]  gap_acc, gap_acc_next;
  logic [5:0]               cand, cand_next;
  logic                     out_status, out_status_next;
  logic [7:0]               out_byte, out_byte_next;
  logic                     out_last, out_last_next;

  // shared subtractor
  logic signed [GAP_W-1:0]  alu_a, alu_b, alu_y;
  assign alu_y = alu_a - alu_b;

  // byte-position advance
  phase_t               adv_phase;
  logic [REGION_W-1:0]  adv_rc;
  logic [4:0]           adv_ri;
  logic                 adv_last;
  logic [REGION_W:0]    rc_inc;
  logic [REGION_W-1:0]  reg_len;
  logic [4:0]           ri_inc;
  logic [7:0]           cur_byte;

  logic                 sc_dd, sc_hd;
  logic [5:0]           trial;
  logic [MASK_IDX_W-1:0] cand_idx;

  assign sc_dd = (cfg_spt >= 5'd1) && (cfg_spt <= 5'd10);
  assign sc_hd = cfg_hd && (cfg_spt >= 5'd13) && ({1'b0, cfg_spt} <= 6'(MAX_SECTORS));
  assign trial = {rem, cfg_ilv[step_cnt[2:0]]};
  assign cand_idx = cand[MASK_IDX_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_spt   <= 5'd9;
      cfg_track <= 8'd0;
      cfg_side  <= 1'b0;
      cfg_ilv   <= 8'sd1;
      cfg_fill  <= 16'd58853;
      cfg_hd    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECTORS:    cfg_spt   <= cfg_data[4:0];
        CFG_TRACK:      cfg_track <= cfg_data[7:0];
        CFG_SIDE:       cfg_side  <= cfg_data[0];
        CFG_INTERLEAVE: cfg_ilv   <= cfg_data[7:0];
        CFG_FILL:       cfg_fill  <= cfg_data;
        CFG_HD_CAPABLE: cfg_hd    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // length of the current region and the position after one byte
  always_comb begin
    unique case (phase)
      PH_LEADER: reg_len = track_is_hd ? LEAD_IN_HD : LEAD_IN_DD;
      PH_GAP2:   reg_len = LEN_GAP2;
      PH_ID:     reg_len = LEN_ID;
      PH_GAP3:   reg_len = LEN_GAP3;
      PH_DHEAD:  reg_len = LEN_DHEAD;
      PH_DATA:   reg_len = LEN_DATA;
      PH_TAIL:   reg_len = LEN_TAIL;
      PH_GAP5:   reg_len = gap5_len;
      default:   reg_len = '0;
    endcase
  end

  always_comb begin
    rc_inc    = {1'b0, region_count} + 1'b1;
    ri_inc    = record_index + 5'd1;
    adv_phase = phase;
    adv_rc    = rc_inc[REGION_W-1:0];
    adv_ri    = record_index;
    adv_last  = 1'b0;
    if (rc_inc >= {1'b0, reg_len}) begin
      adv_rc = '0;
      unique case (phase)
        PH_LEADER: adv_phase = PH_GAP2;
        PH_GAP2:   adv_phase = PH_ID;
        PH_ID:     adv_phase = PH_GAP3;
        PH_GAP3:   adv_phase = PH_DHEAD;
        PH_DHEAD:  adv_phase = PH_DATA;
        PH_DATA:   adv_phase = PH_TAIL;
        PH_TAIL: begin
          adv_ri = ri_inc;
          if (ri_inc < latched_spt) adv_phase = PH_GAP2;
          else if (gap5_len != '0) adv_phase = PH_GAP5;
          else adv_phase = PH_IDLE;
        end
        default:   adv_phase = PH_IDLE;
      endcase
      adv_last = (adv_phase == PH_IDLE);
    end
  end

  // track byte at the current position (sector byte handled apart)
  always_comb begin
    unique case (phase)
      PH_ID: begin
        priority if (region_count < ID_MARK_IDX) cur_byte = B_SYNC;
        else if (region_count == ID_MARK_IDX)    cur_byte = B_IDAM;
        else if (region_count == ID_TRACK_IDX)   cur_byte = cfg_track;
        else if (region_count == ID_SIDE_IDX)    cur_byte = {7'd0, cfg_side};
        else if (region_count == ID_SECTOR_IDX)  cur_byte = req.skew_sector;
        else if (region_count == ID_SIZE_IDX)    cur_byte = B_SIZE;
        else                                     cur_byte = B_CRC;
      end
      PH_GAP2:  cur_byte = B_ZERO;
      PH_GAP3:  cur_byte = (region_count < GAP3_4E_COUNT) ? B_GAP : B_ZERO;
      PH_DHEAD: cur_byte = (region_count < SYNC_COUNT) ? B_SYNC : B_DAM;
      PH_DATA:  cur_byte = region_count[0] ? cfg_fill[7:0] : cfg_fill[15:8];
      PH_TAIL:  cur_byte = (region_count == '0) ? B_CRC : B_GAP;
      default:  cur_byte = B_GAP;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= SEQ_IDLE;
      phase         <= PH_IDLE;
      region_count  <= '0;
      record_index  <= '0;
      sector_offset <= '0;
      used_mask     <= '0;
      eff_ilv       <= 5'd1;
      track_is_hd   <= 1'b0;
      latched_spt   <= 5'd9;
      gap5_len      <= '0;
      step_cnt      <= '0;
    end else begin
      seq           <= seq_next;
      phase         <= phase_next;
      region_count  <= region_count_next;
      record_index  <= record_index_next;
      sector_offset <= sector_offset_next;
      used_mask     <= used_mask_next;
      eff_ilv       <= eff_ilv_next;
      track_is_hd   <= track_is_hd_next;
      latched_spt   <= latched_spt_next;
      gap5_len      <= gap5_len_next;
      step_cnt      <= step_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rem        <= rem_next;
    gap_acc    <= gap_acc_next;
    cand       <= cand_next;
    out_status <= out_status_next;
    out_byte   <= out_byte_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    seq_next           = seq;
    phase_next         = phase;
    region_count_next  = region_count;
    record_index_next  = record_index;
    sector_offset_next = sector_offset;
    used_mask_next     = used_mask;
    eff_ilv_next       = eff_ilv;
    track_is_hd_next   = track_is_hd;
    latched_spt_next   = latched_spt;
    gap5_len_next      = gap5_len;
    rem_next           = rem;
    step_cnt_next      = step_cnt;
    gap_acc_next       = gap_acc;
    cand_next          = cand;
    out_status_next    = out_status;
    out_byte_next      = out_byte;
    out_last_next      = out_last;
    alu_a              = '0;
    alu_b              = '0;
    req.ready          = (seq == SEQ_IDLE);
    rsp.valid          = (seq == SEQ_OUT);

    unique case (seq)
      SEQ_IDLE: begin
        if (req.valid) begin
          out_status_next = ST_OK;
          out_byte_next   = B_ZERO;
          out_last_next   = 1'b0;
          if (req.opcode == OP_BEGIN) begin
            if (sc_dd || sc_hd) begin
              latched_spt_next   = cfg_spt;
              track_is_hd_next   = !sc_dd;
              phase_next         = PH_LEADER;
              region_count_next  = '0;
              record_index_next  = '0;
              sector_offset_next = '0;
              used_mask_next     = '0;
              gap_acc_next       = sc_dd ? GAP_BASE_DD : GAP_BASE_HD;
              if (cfg_ilv[7]) begin
                eff_ilv_next  = '0;
                step_cnt_next = cfg_spt;
                seq_next      = SEQ_GAP;
              end else begin
                rem_next      = '0;
                step_cnt_next = 5'd6;
                seq_next      = SEQ_MOD;
              end
            end else begin
              phase_next      = PH_IDLE;
              out_status_next = ST_ERROR;
              seq_next        = SEQ_OUT;
            end
          end else if (phase == PH_IDLE) begin
            out_status_next = ST_ERROR;
            seq_next        = SEQ_OUT;
          end else if (phase == PH_ID && region_count == ID_SECTOR_IDX && eff_ilv != '0) begin
            cand_next = (record_index == '0) ? 6'd0 : ({1'b0, sector_offset[4:0]}
                                                       + {1'b0, eff_ilv});
            seq_next  = SEQ_SEEK;
          end else begin
            out_byte_next     = cur_byte;
            out_last_next     = adv_last;
            phase_next        = adv_phase;
            region_count_next = adv_rc;
            record_index_next = adv_ri;
            seq_next          = SEQ_OUT;
          end
        end
      end

      // interleave mod sector count, one bit per step
      SEQ_MOD: begin
        alu_a = GAP_W'(trial);
        alu_b = GAP_W'(latched_spt);
        rem_next = alu_y[GAP_W-1] ? trial[4:0] : alu_y[4:0];
        step_cnt_next = step_cnt - 5'd1;
        if (step_cnt == '0) begin
          eff_ilv_next  = (rem_next == '0) ? 5'd1 : rem_next;
          step_cnt_next = latched_spt;
          seq_next      = SEQ_GAP;
        end
      end

      // final gap: base less one disk record per sector, floored at zero
      SEQ_GAP: begin
        if (step_cnt == '0) begin
          gap5_len_next = (gap_acc > 0) ? gap_acc[REGION_W-1:0] : '0;
          seq_next      = SEQ_OUT;
        end else begin
          alu_a         = gap_acc;
          alu_b         = GAP_RECORD;
          gap_acc_next  = alu_y;
          step_cnt_next = step_cnt - 5'd1;
        end
      end

      // free slot search: wrap, else skip a used slot, else take it
      SEQ_SEEK: begin
        priority if (cand >= {1'b0, latched_spt}) begin
          alu_a     = GAP_W'(cand);
          alu_b     = GAP_W'(latched_spt);
          cand_next = alu_y[5:0];
        end else if (used_mask[cand_idx]) begin
          alu_a     = GAP_W'(cand);
          alu_b     = -GAP_W'(1);
          cand_next = alu_y[5:0];
        end else begin
          used_mask_next     = used_mask | ({{(MAX_SECTORS-1){1'b0}}, 1'b1} << cand_idx);
          sector_offset_next = cand;
          out_byte_next      = {2'b00, cand} + 8'd1;
          out_last_next      = adv_last;
          phase_next         = adv_phase;
          region_count_next  = adv_rc;
          record_index_next  = adv_ri;
          seq_next           = SEQ_OUT;
        end
      end

      SEQ_OUT: begin
        if (rsp.ready) seq_next = SEQ_IDLE;
      end

      default: seq_next = SEQ_IDLE;
    endcase
  end

  assign rsp.status    = out_status;
  assign rsp.data_byte = out_byte;
  assign rsp.last_byte = out_last;

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request taken while a result is pending");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last_byte) |-> (phase == PH_IDLE && rsp.status == ST_OK))
    else $error("last byte shown while the image is still running");

  a_seek_mode: assert property (@(posedge clk) disable iff (rst)
    (seq == SEQ_SEEK) |-> (eff_ilv != '0 && phase == PH_ID))
    else $error("slot search outside an interleaved ID field");

  a_idle_emit: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.opcode == OP_EMIT && phase == PH_IDLE)
      |=> (rsp.valid && rsp.status == ST_ERROR))
    else $error("emit with no image did not report an error");
`endif

endmodule

[sim/floppy_track_format_image_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floppy_track_format_image_test
// Self-checking testbench for the track format image generator. A model of
// the generator runs alongside the block and predicts every result byte;
// results are compared in order as they leave the block. Stimulus covers
// sector count checks, live and latched registers, the opening bytes of DD
// and HD images, interleave and skew numbering, abandoned images and random
// request mixes, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module floppy_track_format_image_test;
  import ftfi_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int START_BYTES   = 8;
  localparam int FIRST_ID_BYTES = 80;
  localparam int MAX_REPORTS   = 100;

  // track layout
  localparam int DD_TRACK_BYTES  = 6250;
  localparam int HD_TRACK_BYTES  = 12500;
  localparam int LEAD_IN_DD_BYTES = 60;
  localparam int LEAD_IN_HD_BYTES = 120;
  localparam int GAP2_BYTES      = 12;
  localparam int ID_BYTES        = 9;
  localparam int GAP3_BYTES      = 34;
  localparam int GAP3_FILL_BYTES = 22;
  localparam int SYNC_BYTES      = 3;
  localparam int DATA_HEAD_BYTES = 4;
  localparam int DATA_FIELD_BYTES = 512;
  localparam int TAIL_BYTES      = 41;
  localparam int RECORD_ON_DISK  = DATA_FIELD_BYTES + 102;
  localparam int DD_MAX_SECTORS  = 10;
  localparam int HD_MIN_SECTORS  = 13;
  localparam int HD_MAX_SECTORS  = 20;

  localparam logic [7:0] GAP_BYTE  = 8'h4E;
  localparam logic [7:0] SYNC_BYTE = 8'hF5;
  localparam logic [7:0] ID_MARK   = 8'hFE;
  localparam logic [7:0] DATA_MARK = 8'hFB;
  localparam logic [7:0] CRC_MARK  = 8'hF7;
  localparam logic [7:0] SIZE_CODE = 8'h02;

  typedef struct packed {
    logic       status;
    logic [7:0] data_byte;
    logic       last_byte;
  } track_byte_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE} rx_pattern_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ftfi_req_if req ();
  ftfi_rsp_if rsp ();

  floppy_track_format_image DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  track_byte_t track_bytes_due[$];
  int          failures          = 0;
  int          cycle_count       = 0;
  int          requests_accepted = 0;
  int          results_checked   = 0;
  int          images_completed  = 0;
  int          error_results     = 0;
  int          burst_left        = 0;
  logic        sender_steady     = 1'b0;
  int          rx_hold_left      = 0;
  rx_pattern_t rx_pattern        = RX_RANDOM;

  // register copies
  logic [4:0]  cfg_sectors;
  logic [7:0]  cfg_track;
  logic        cfg_side;
  logic [7:0]  cfg_interleave;
  logic [15:0] cfg_fill;
  logic        cfg_hd_capable;

  // generator state
  phase_t      gen_phase;
  int unsigned gen_region;
  logic [4:0]  gen_record;
  int unsigned gen_slot;
  logic [31:0] gen_slots_used;
  int unsigned gen_step;      // 0 selects skew numbering
  logic        gen_hd;
  int unsigned gen_sectors;

  function automatic void reset_generator();
    cfg_sectors    = 5'd9;
    cfg_track      = 8'd0;
    cfg_side       = 1'b0;
    cfg_interleave = 8'd1;
    cfg_fill       = 16'hE5E5;
    cfg_hd_capable = 1'b0;
    gen_phase      = PH_IDLE;
    gen_region     = 0;
    gen_record     = '0;
    gen_slot       = 0;
    gen_slots_used = '0;
    gen_step       = 1;
    gen_hd         = 1'b0;
    gen_sectors    = 9;
  endfunction

  function automatic int unsigned final_gap_bytes();
    int track_len;
    int g;
    track_len = gen_hd ? HD_TRACK_BYTES : DD_TRACK_BYTES;
    g = track_len - (gen_hd ? LEAD_IN_HD_BYTES : LEAD_IN_DD_BYTES)
        - RECORD_ON_DISK * int'(gen_sectors);
    return (g > 0) ? g : 0;
  endfunction

  function automatic int unsigned region_bytes(phase_t p);
    case (p)
      PH_LEADER: return gen_hd ? LEAD_IN_HD_BYTES : LEAD_IN_DD_BYTES;
      PH_GAP2:   return GAP2_BYTES;
      PH_ID:     return ID_BYTES;
      PH_GAP3:   return GAP3_BYTES;
      PH_DHEAD:  return DATA_HEAD_BYTES;
      PH_DATA:   return DATA_FIELD_BYTES;
      PH_TAIL:   return TAIL_BYTES;
      PH_GAP5:   return final_gap_bytes();
      default:   return 0;
    endcase
  endfunction

  // first record takes slot 0; later ones step by the interleave and probe
  // forward past slots already taken
  function automatic logic [7:0] next_sector_number();
    int unsigned span;
    int unsigned cand;
    int          k;
    span = (gen_sectors != 0) ? gen_sectors : 1;
    cand = (gen_record == 0) ? 0 : (gen_slot + gen_step) % span;
    for (k = 0; k < 64 && gen_slots_used[cand]; k++)
      cand = (cand + 1) % span;
    gen_slots_used[cand] = 1'b1;
    gen_slot = cand;
    return 8'(cand + 1);
  endfunction

  function automatic logic [7:0] id_field_byte(int unsigned idx, logic [7:0] skew);
    if (idx < SYNC_BYTES) return SYNC_BYTE;
    case (idx)
      3:       return ID_MARK;
      4:       return cfg_track;
      5:       return {7'd0, cfg_side};
      6:       return (gen_step != 0) ? next_sector_number() : skew;
      7:       return SIZE_CODE;
      default: return CRC_MARK;
    endcase
  endfunction

  function automatic track_byte_t predict_track_byte(logic op, logic [7:0] skew);
    track_byte_t r;
    int unsigned idx;
    int unsigned sc;
    logic        dd_ok;
    logic        hd_ok;
    r = '0;
    r.status = ST_OK;
    if (op == OP_BEGIN) begin
      sc = cfg_sectors;
      dd_ok = (sc >= 1) && (sc <= DD_MAX_SECTORS);
      hd_ok = cfg_hd_capable && (sc >= HD_MIN_SECTORS) && (sc <= HD_MAX_SECTORS);
      if (dd_ok || hd_ok) begin
        gen_sectors = sc;
        gen_hd = !dd_ok;
        if (cfg_interleave[7]) begin
          gen_step = 0;
        end else begin
          gen_step = int'(cfg_interleave) % sc;
          if (gen_step == 0) gen_step = 1;
        end
        gen_phase      = PH_LEADER;
        gen_region     = 0;
        gen_record     = '0;
        gen_slot       = 0;
        gen_slots_used = '0;
      end else begin
        gen_phase = PH_IDLE;
        r.status = ST_ERROR;
      end
    end else if (gen_phase == PH_IDLE) begin
      r.status = ST_ERROR;
    end else begin
      idx = gen_region;
      case (gen_phase)
        PH_LEADER: r.data_byte = GAP_BYTE;
        PH_GAP2:   r.data_byte = 8'h00;
        PH_ID:     r.data_byte = id_field_byte(idx, skew);
        PH_GAP3:   r.data_byte = (idx < GAP3_FILL_BYTES) ? GAP_BYTE : 8'h00;
        PH_DHEAD:  r.data_byte = (idx < SYNC_BYTES) ? SYNC_BYTE : DATA_MARK;
        PH_DATA:   r.data_byte = (idx % 2) ? cfg_fill[7:0] : cfg_fill[15:8];
        PH_TAIL:   r.data_byte = (idx == 0) ? CRC_MARK : GAP_BYTE;
        default:   r.data_byte = GAP_BYTE;
      endcase
      gen_region = idx + 1;
      if (gen_region >= region_bytes(gen_phase)) begin
        gen_region = 0;
        if (gen_phase == PH_TAIL) begin
          gen_record = gen_record + 5'd1;
          if (gen_record < gen_sectors) gen_phase = PH_GAP2;
          else gen_phase = (final_gap_bytes() > 0) ? PH_GAP5 : PH_IDLE;
        end else if (gen_phase == PH_GAP5) begin
          gen_phase = PH_IDLE;
        end else if (gen_phase == PH_LEADER) begin
          gen_phase = PH_GAP2;
        end else begin
          gen_phase = phase_t'(gen_phase + 4'd1);
        end
        if (gen_phase == PH_IDLE) r.last_byte = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    failures++;
    if (failures <= MAX_REPORTS)
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
  endtask

  always @(posedge clk) begin : result_check
    track_byte_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, track_bytes_due.size());
      $display("== FAIL ==");
      $finish;
    end
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      results_checked++;
      if (track_bytes_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $error("result with no request outstanding: status %0b byte 0x%02h",
                 rsp.status, rsp.data_byte);
      end else begin
        want = track_bytes_due.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", want.status, rsp.status);
        if (rsp.data_byte !== want.data_byte)
          report_mismatch("data_byte", want.data_byte, rsp.data_byte);
        if (rsp.last_byte !== want.last_byte)
          report_mismatch("last_byte", want.last_byte, rsp.last_byte);
        if (want.last_byte) images_completed++;
        if (want.status == ST_ERROR) error_results++;
      end
    end
  end

  // receiver: a long hold-off wins over the current stall pattern
  initial begin : rsp_receiver
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rsp.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        case (rx_pattern)
          RX_ALWAYS: rsp.ready <= 1'b1;
          RX_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
          default:   rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic pace_sender();
    int gap;
    if (sender_steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic send_request(input logic op, input logic [7:0] skew,
                              output track_byte_t due);
    @(negedge clk);
    req.valid       <= 1'b1;
    req.opcode      <= op;
    req.skew_sector <= skew;
    do @(posedge clk); while (req.ready !== 1'b1);
    due = predict_track_byte(op, skew);
    track_bytes_due.push_back(due);
    requests_accepted++;
    pace_sender();
  endtask

  // drop a stale request and wait for every result to come back
  task automatic settle_results();
    if (req.valid) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    while (track_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    settle_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SECTORS:    cfg_sectors    = value[4:0];
      CFG_TRACK:      cfg_track      = value[7:0];
      CFG_SIDE:       cfg_side       = value[0];
      CFG_INTERLEAVE: cfg_interleave = value[7:0];
      CFG_FILL:       cfg_fill       = value;
      CFG_HD_CAPABLE: cfg_hd_capable = value[0];
      default: ;
    endcase
  endtask

  task automatic poke_register();
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    idx = CFG_IDX_W'($urandom_range(CFG_SECTORS, CFG_HD_CAPABLE));
    case (idx)
      CFG_SECTORS:    value = 16'($urandom_range(0, 31));
      CFG_TRACK:      value = 16'($urandom_range(0, 255));
      CFG_INTERLEAVE: value = 16'($urandom_range(0, 255));
      CFG_FILL:       value = 16'($urandom_range(0, 65535));
      default:        value = 16'($urandom_range(0, 1));
    endcase
    write_register(idx, value);
  endtask

  task automatic setup_track(input logic [4:0] count, input logic hd_capable,
                             input logic [7:0] il, input logic [7:0] trk,
                             input logic sd, input logic [15:0] fill);
    write_register(CFG_SECTORS, 16'(count));
    write_register(CFG_HD_CAPABLE, 16'(hd_capable));
    write_register(CFG_INTERLEAVE, 16'(il));
    write_register(CFG_TRACK, 16'(trk));
    write_register(CFG_SIDE, 16'(sd));
    write_register(CFG_FILL, fill);
  endtask

  // begin an image and emit up to max_emits bytes; a finished image gets one
  // more emit, which must come back as an idle error
  task automatic run_track(input int max_emits);
    track_byte_t due;
    int          n;
    send_request(OP_BEGIN, 8'($urandom_range(0, 255)), due);
    n = 0;
    do begin
      if ($urandom_range(0, 499) == 0) poke_register();
      send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
      n++;
    end while (!due.last_byte && n < max_emits);
    if (due.last_byte) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
  endtask

  task automatic test_sector_counts();
    track_byte_t due;
    logic [4:0]  dd_bad [0:4] = '{5'd11, 5'd12, 5'd13, 5'd21, 5'd31};
    logic [4:0]  hd_try [0:3] = '{5'd13, 5'd20, 5'd21, 5'd0};
    int          i;
    rx_pattern = RX_RANDOM;
    send_request(OP_EMIT, 8'hFF, due);          // nothing started yet
    send_request(OP_BEGIN, 8'h00, due);         // reset count, 9 sectors DD
    repeat (3) send_request(OP_EMIT, 8'h00, due);
    write_register(CFG_SECTORS, 16'd0);
    send_request(OP_BEGIN, 8'hFF, due);         // bad count drops the image
    send_request(OP_EMIT, 8'hFF, due);
    for (i = 0; i < 5; i++) begin
      write_register(CFG_SECTORS, 16'(dd_bad[i]));
      send_request(OP_BEGIN, 8'($urandom_range(0, 255)), due);
    end
    write_register(CFG_HD_CAPABLE, 16'd1);
    for (i = 0; i < 4; i++) begin
      write_register(CFG_SECTORS, 16'(hd_try[i]));
      send_request(OP_BEGIN, 8'($urandom_range(0, 255)), due);
      send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
    end
    write_register(CFG_HD_CAPABLE, 16'd0);
    write_register(CFG_SECTORS, 16'd20);
    send_request(OP_BEGIN, 8'h00, due);
    write_register(CFG_SECTORS, 16'd10);
    send_request(OP_BEGIN, 8'h00, due);
    write_register(CFG_SECTORS, 16'd1);
    send_request(OP_BEGIN, 8'h00, due);
    send_request(OP_EMIT, 8'h00, due);
  endtask

  // track, side and fill are read live; count, interleave and density are
  // held from the begin request
  task automatic test_live_registers();
    track_byte_t due;
    setup_track(5'd2, 1'b0, 8'd1, 8'h00, 1'b0, 16'h1234);
    send_request(OP_BEGIN, 8'h00, due);
    repeat (70) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
    write_register(CFG_TRACK, 16'd255);
    write_register(CFG_SIDE, 16'd1);
    write_register(CFG_SECTORS, 16'd31);
    write_register(CFG_INTERLEAVE, 16'h0080);
    write_register(CFG_HD_CAPABLE, 16'd1);
    repeat (30) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
    write_register(CFG_FILL, 16'h0FF0);
    repeat (25) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
    // begin while busy, first with a bad count, then a good one
    send_request(OP_BEGIN, 8'h00, due);
    send_request(OP_EMIT, 8'h00, due);
    write_register(CFG_SECTORS, 16'd3);
    send_request(OP_BEGIN, 8'h00, due);
    repeat (5) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
    send_request(OP_BEGIN, 8'h00, due);
    repeat (5) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
  endtask

  task automatic test_backpressure();
    track_byte_t due;
    setup_track(5'd9, 1'b0, 8'd3, 8'($urandom_range(0, 255)), 1'b0, 16'hA55A);
    sender_steady = 1'b1;
    rx_pattern = RX_ALWAYS;
    send_request(OP_BEGIN, 8'h00, due);
    rx_hold_left = 400;
    repeat (20) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
    settle_results();
    rx_pattern = RX_SPARSE;
    repeat (20) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
    rx_hold_left = 250;
    send_request(OP_BEGIN, 8'h00, due);
    repeat (6) send_request(OP_EMIT, 8'($urandom_range(0, 255)), due);
    sender_steady = 1'b0;
    rx_pattern = RX_RANDOM;
  endtask

  task automatic test_track_starts();
    // one sector: interleave 1 mod 1 falls back to 1
    setup_track(5'd1, 1'b0, 8'd1, 8'd0, 1'b0, 16'h0000);
    rx_pattern = RX_ALWAYS;
    sender_steady = 1'b1;
    run_track(START_BYTES);
    // 127 mod 10 gives a step of 7
    setup_track(5'd10, 1'b0, 8'd127, 8'd255, 1'b1, 16'hFFFF);
    rx_pattern = RX_RANDOM;
    sender_steady = 1'b0;
    run_track(START_BYTES);
    // zero interleave means 1
    setup_track(5'd20, 1'b1, 8'd0, 8'($urandom_range(0, 255)), 1'b1,
                16'($urandom_range(0, 65535)));
    rx_pattern = RX_SPARSE;
    run_track(START_BYTES);
    // most negative interleave selects skew numbering
    setup_track(5'd13, 1'b1, 8'h80, 8'($urandom_range(0, 255)), 1'b0,
                16'($urandom_range(0, 65535)));
    rx_pattern = RX_RANDOM;
    run_track(START_BYTES);
    // skew numbering into the first ID field, past its sector byte
    setup_track(5'd9, 1'b0, 8'hF0, 8'($urandom_range(0, 255)), 1'b1,
                16'($urandom_range(0, 65535)));
    run_track(FIRST_ID_BYTES);
  endtask

  task automatic test_random_tracks();
    logic [4:0] count;
    logic       hd_capable;
    logic [7:0] il;
    int         i;
    for (i = 0; i < 4; i++) begin
      if ($urandom_range(0, 1)) begin
        count = 5'($urandom_range(1, DD_MAX_SECTORS));
        hd_capable = 1'($urandom_range(0, 1));
      end else begin
        count = 5'($urandom_range(HD_MIN_SECTORS, HD_MAX_SECTORS));
        hd_capable = 1'b1;
      end
      il = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(128, 255))
                                       : 8'($urandom_range(0, 24));
      setup_track(count, hd_capable, il, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      rx_pattern = rx_pattern_t'($urandom_range(0, 2));
      sender_steady = ($urandom_range(0, 3) == 0);
      run_track($urandom_range(8, 24));
    end
  endtask

  // short images, restarts, bad counts and emits while idle
  task automatic test_random_mix();
    track_byte_t due;
    int          i;
    for (i = 0; i < 40; i++) begin
      if (i % 10 == 0) begin
        poke_register();
        rx_pattern = rx_pattern_t'($urandom_range(0, 2));
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      send_request(($urandom_range(0, 3) == 0) ? OP_BEGIN : OP_EMIT,
                   8'($urandom_range(0, 255)), due);
    end
  endtask

  initial begin
    req.valid       = 1'b0;
    req.opcode      = OP_EMIT;
    req.skew_sector = 8'h00;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SECTORS;
    cfg_data        = '0;
    reset_generator();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_sector_counts();
    test_live_registers();
    test_backpressure();
    test_track_starts();
    test_random_tracks();
    test_random_mix();

    settle_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests; checked %0d results, %0d whole track images",
             requests_accepted, results_checked, images_completed);
    $display("Error statuses: %0d; failures seen: %0d", error_results, failures);
    if (failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
